@@ src/i2cm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, codes and the phase count table shared by the byte controller files.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    localparam int STEP_W  = 5;
    localparam int TICK_W  = 16;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;

    // number of bit phases in a byte and the phase of the first bit in a read
    localparam logic [STEP_W-1:0] BIT_PHASES    = 5'd24;
    localparam logic [STEP_W-1:0] READ_FIRST_BIT = 5'd1;

    // classified item handed from the front to the engine
    typedef struct packed {
        logic       is_cmd;
        op_t        op;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [1:0] pad;
        logic       rejected;
        logic       ack_seen;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } result_t;

    function automatic logic [STEP_W-1:0] phase_total(input op_t op);
        logic [STEP_W-1:0] n;
        case (op)
            OP_START: n = 5'd4;
            OP_STOP:  n = 5'd3;
            OP_WRITE: n = 5'd27;
            OP_READ:  n = 5'd28;
            default:  n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

@@ src/i2cm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// Unpacks an input item and classifies it as tick or command with its operation.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  logic [i2cm_pkg::IN_W-1:0] tdata,
    input  logic [0:0]                tuser,
    output i2cm_pkg::item_t           item
);
    import i2cm_pkg::*;

    cmd_t cmd;

    assign cmd = cmd_t'(tdata[1:0]);

    always_comb
    begin
        item.is_cmd   = tuser[0];
        item.tx_byte  = tdata[9:2];
        item.send_ack = tdata[10];
        item.sda_in   = tdata[11];
        case (cmd)
            CMD_START: item.op = OP_START;
            CMD_STOP:  item.op = OP_STOP;
            CMD_WRITE: item.op = OP_WRITE;
            CMD_READ:  item.op = OP_READ;
            default:   item.op = OP_IDLE;
        endcase
    end

endmodule

@@ src/i2cm_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_queue
// Small register queue between the front and the engine.
// ----------------------------------------------------------------------------
module i2cm_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i2cm_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output i2cm_pkg::item_t pop_item,
    output logic            not_empty
);
    import i2cm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = slot_reg[rd_ptr_reg];

    // depth is a power of two so the pointers wrap on their own
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/i2cm_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus phase sequencer: one item per cycle unless stalled; registers its result.
// ----------------------------------------------------------------------------
module i2cm_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [i2cm_pkg::TICK_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    input  i2cm_pkg::item_t               in_item,
    output logic                          in_ready,
    output logic                          out_valid,
    output i2cm_pkg::result_t             out_result,
    input  logic                          out_ready
);
    import i2cm_pkg::*;

    logic [TICK_W-1:0] phase_ticks_reg;
    op_t               op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        sub_reg, sub_next;
    logic [7:0]        shift_reg, shift_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              ack_flag_reg, ack_flag_next;
    logic              ack_send_reg, ack_send_next;
    logic [7:0]        rx_reg, rx_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic              fire;
    logic              done;
    logic              rej;
    logic              apply;
    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] tick_inc;
    logic [STEP_W-1:0] step_inc;

    assign in_ready   = !out_valid_reg || out_ready;
    assign fire       = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign limit      = (phase_ticks_reg == '0) ? TICK_W'(1) : phase_ticks_reg;
    assign tick_inc   = tick_reg + 1'b1;
    assign step_inc   = step_reg + 1'b1;

    always_comb
    begin
        op_next       = op_reg;
        step_next     = step_reg;
        sub_next      = sub_reg;
        shift_next    = shift_reg;
        tick_next     = tick_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        ack_flag_next = ack_flag_reg;
        ack_send_next = ack_send_reg;
        rx_next       = rx_reg;
        done          = 1'b0;
        rej           = 1'b0;
        apply         = 1'b0;

        if (in_item.is_cmd)
        begin
            if (op_reg != OP_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                op_next       = in_item.op;
                step_next     = '0;
                sub_next      = 2'd0;
                tick_next     = '0;
                ack_send_next = in_item.send_ack;
                if (in_item.op == OP_WRITE)
                begin
                    shift_next = in_item.tx_byte;
                end
                else if (in_item.op == OP_READ)
                begin
                    shift_next = 8'h00;
                end
                apply = 1'b1;
            end
        end
        else if (op_reg != OP_IDLE)
        begin
            if (tick_inc >= limit)
            begin
                tick_next = '0;
                if (step_inc >= phase_total(op_reg))
                begin
                    if (op_reg == OP_READ)
                    begin
                        rx_next = shift_reg;
                    end
                    op_next   = OP_IDLE;
                    step_next = '0;
                    done      = 1'b1;
                end
                else
                begin
                    step_next = step_inc;
                    // sub tracks the position inside a three-phase bit slot
                    if (op_reg == OP_READ && step_inc == READ_FIRST_BIT)
                    begin
                        sub_next = 2'd0;
                    end
                    else
                    begin
                        sub_next = (sub_reg == 2'd2) ? 2'd0 : sub_reg + 2'd1;
                    end
                    apply = 1'b1;
                end
            end
            else
            begin
                tick_next = tick_inc;
            end
        end

        if (apply)
        begin
            case (op_next)
                OP_START:
                begin
                    case (step_next)
                        5'd0:    scl_next = 1'b1;
                        5'd1:    sda_next = 1'b1;
                        5'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                end
                OP_STOP:
                begin
                    case (step_next)
                        5'd0:    sda_next = 1'b0;
                        5'd1:    scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                end
                OP_WRITE:
                begin
                    if (step_next < BIT_PHASES)
                    begin
                        case (sub_next)
                            2'd0:    sda_next = shift_next[7];
                            2'd1:    scl_next = 1'b1;
                            default:
                            begin
                                scl_next   = 1'b0;
                                shift_next = {shift_next[6:0], 1'b0};
                            end
                        endcase
                    end
                    else if (step_next == BIT_PHASES)
                    begin
                        sda_next = 1'b1;
                    end
                    else if (step_next == BIT_PHASES + 5'd1)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        ack_flag_next = !in_item.sda_in;
                        scl_next      = 1'b0;
                    end
                end
                OP_READ:
                begin
                    if (step_next == '0)
                    begin
                        sda_next = 1'b1;
                    end
                    else if (step_next <= BIT_PHASES)
                    begin
                        case (sub_next)
                            2'd0:    scl_next = 1'b1;
                            2'd1:    shift_next = {shift_next[6:0], in_item.sda_in};
                            default: scl_next = 1'b0;
                        endcase
                    end
                    else if (step_next == BIT_PHASES + 5'd1)
                    begin
                        sda_next = !ack_send_next;
                    end
                    else if (step_next == BIT_PHASES + 5'd2)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        out_next.pad      = 2'b00;
        out_next.scl_out  = scl_next;
        out_next.sda_out  = sda_next;
        out_next.busy_res = (op_next != OP_IDLE);
        out_next.done_res = done;
        out_next.rx_byte  = rx_next;
        out_next.ack_seen = ack_flag_next;
        out_next.rejected = rej;

        out_valid_next = fire ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= TICK_W'(5);
            op_reg          <= OP_IDLE;
            step_reg        <= '0;
            sub_reg         <= 2'd0;
            shift_reg       <= 8'h00;
            tick_reg        <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            ack_flag_reg    <= 1'b0;
            ack_send_reg    <= 1'b0;
            rx_reg          <= 8'h00;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                phase_ticks_reg <= cfg_wr_data;
            end
            if (fire)
            begin
                op_reg       <= op_next;
                step_reg     <= step_next;
                sub_reg      <= sub_next;
                shift_reg    <= shift_next;
                tick_reg     <= tick_next;
                scl_reg      <= scl_next;
                sda_reg      <= sda_next;
                ack_flag_reg <= ack_flag_next;
                ack_send_reg <= ack_send_next;
                rx_reg       <= rx_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

endmodule

@@ src/i2c_master_byte_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_controller
// Byte-level I2C master: start, stop, write byte and read byte by bus phases.
// ----------------------------------------------------------------------------
// Every input item, tick or command, gives exactly one result item. The block
// takes one item per clock cycle while the queue is not full and the output is
// not stalled; the phase sequencer updates its whole registered state from each
// item it takes. An accepted item is written into a queue slot, is then taken
// by the sequencer, and its result is offered on the output register. The
// queue lets the input keep flowing while a result waits.
module i2c_master_byte_controller #(
    parameter int QUEUE_DEPTH = 2  // power of two, 2 to 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [i2cm_pkg::TICK_W-1:0] cfg_wr_data,   // phase_ticks
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // command[1:0], tx_byte[9:2], send_ack[10], sda_in[11], zero[15:12]
    input  logic [i2cm_pkg::IN_W-1:0]   s_axis_tdata,
    // mode[0]
    input  logic [0:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4],
    // ack_seen[12], rejected[13], zero[15:14]
    output logic [i2cm_pkg::OUT_W-1:0]  m_axis_tdata
);
    import i2cm_pkg::*;

    item_t   front_item;
    item_t   q_item;
    logic    q_full;
    logic    q_not_empty;
    logic    eng_ready;
    result_t eng_result;

    assign s_axis_tready = !q_full;
    assign m_axis_tdata  = eng_result;

    i2cm_front u_front (
        .tdata (s_axis_tdata),
        .tuser (s_axis_tuser),
        .item  (front_item)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid),
        .push_item (front_item),
        .full      (q_full),
        .pop       (eng_ready),
        .pop_item  (q_item),
        .not_empty (q_not_empty)
    );

    i2cm_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (q_not_empty),
        .in_item     (q_item),
        .in_ready    (eng_ready),
        .out_valid   (m_axis_tvalid),
        .out_result  (eng_result),
        .out_ready   (m_axis_tready)
    );

endmodule

@@ src/i2cm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the result stream of the byte controller.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [i2cm_pkg::OUT_W-1:0]  m_axis_tdata
);
    import i2cm_pkg::*;

    result_t res;

    assign res = m_axis_tdata;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_done_not_rej: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(res.done_res && res.rejected))
        else $error("item both finished and rejected");

    // finishing an operation leaves the controller idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.done_res |-> !res.busy_res)
        else $error("busy after operation finished");

    // a rejected command comes while an operation runs and leaves it busy
    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.rejected |-> res.busy_res)
        else $error("command rejected while idle");

endmodule

bind i2c_master_byte_controller i2cm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
